@@ hw/rtl/tfs_pkg.sv @@
// Package for the TFT rectangle fill byte streamer.
// Holds the shared widths, display command codes, header positions and structs.
// Has no dependencies.
package tfs_pkg;

    localparam int COORD_W = 10;
    localparam int COLOR_W = 16;
    localparam int BYTE_W  = 8;
    localparam int HDR_W   = 4;
    localparam int AREA_W  = 2 * COORD_W;
    localparam int COUNT_W = AREA_W + 1;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [COLOR_W-1:0] color_t;
    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [HDR_W-1:0]   hdr_pos_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam byte_t CMD_COLUMN_SET = 8'h2A;
    localparam byte_t CMD_PAGE_SET   = 8'h2B;
    localparam byte_t CMD_MEM_WRITE  = 8'h2C;

    localparam hdr_pos_t HDR_COL_CMD   = 4'd0;
    localparam hdr_pos_t HDR_COL_X0_HI = 4'd1;
    localparam hdr_pos_t HDR_COL_X0_LO = 4'd2;
    localparam hdr_pos_t HDR_COL_X1_HI = 4'd3;
    localparam hdr_pos_t HDR_COL_X1_LO = 4'd4;
    localparam hdr_pos_t HDR_PAGE_CMD  = 4'd5;
    localparam hdr_pos_t HDR_PAGE_Y0_HI = 4'd6;
    localparam hdr_pos_t HDR_PAGE_Y0_LO = 4'd7;
    localparam hdr_pos_t HDR_PAGE_Y1_HI = 4'd8;
    localparam hdr_pos_t HDR_PAGE_Y1_LO = 4'd9;
    localparam hdr_pos_t HDR_MEM_CMD   = 4'd10;
    localparam hdr_pos_t HDR_DONE      = 4'd11;

    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    localparam coord_t SCREEN_WIDTH_RESET  = 10'd320;
    localparam coord_t SCREEN_HEIGHT_RESET = 10'd240;

    typedef struct packed {
        logic   accept;
        coord_t col_start;
        coord_t col_end;
        coord_t row_start;
        coord_t row_end;
        coord_t width;
        coord_t height;
    } window_t;

    typedef struct packed {
        logic valid;
        logic pull;
    } item_ctl_t;

endpackage

@@ hw/rtl/tfs_clip.sv @@
// Clipping of a requested rectangle against the panel size.
// Decides whether a start item is taken and gives the clipped address window.
// Depends on tfs_pkg.
module tfs_clip (
    input  tfs_pkg::coord_t  screen_width,
    input  tfs_pkg::coord_t  screen_height,
    input  tfs_pkg::coord_t  rect_x,
    input  tfs_pkg::coord_t  rect_y,
    input  tfs_pkg::coord_t  rect_w,
    input  tfs_pkg::coord_t  rect_h,
    output tfs_pkg::window_t window
);
    import tfs_pkg::*;

    logic [COORD_W:0] x_end;
    logic [COORD_W:0] y_end;
    coord_t           w_clip;
    coord_t           h_clip;

    assign x_end  = {1'b0, rect_x} + {1'b0, rect_w};
    assign y_end  = {1'b0, rect_y} + {1'b0, rect_h};
    assign w_clip = (x_end > {1'b0, screen_width}) ? (screen_width - rect_x) : rect_w;
    assign h_clip = (y_end > {1'b0, screen_height}) ? (screen_height - rect_y) : rect_h;

    always_comb
    begin
        window.accept    = (rect_x < screen_width) && (rect_y < screen_height)
                           && (rect_w != '0) && (rect_h != '0);
        window.col_start = rect_x;
        window.col_end   = rect_x + w_clip - coord_t'(1);
        window.row_start = rect_y;
        window.row_end   = rect_y + h_clip - coord_t'(1);
        window.width     = w_clip;
        window.height    = h_clip;
    end

endmodule

@@ hw/rtl/tfs_stream.sv @@
// Stream state and result register of the TFT rectangle fill byte streamer.
// Holds the address window, colour and byte counter and selects each outgoing byte.
// Depends on tfs_pkg; takes its window from tfs_clip.
module tfs_stream (
    input  logic               clk,
    input  logic               rst_n,
    input  tfs_pkg::item_ctl_t ctl,
    input  tfs_pkg::window_t   window,
    input  tfs_pkg::color_t    color,
    input  logic               out_stall,
    output logic               advance,
    output logic               out_valid,
    output tfs_pkg::byte_t     spi_byte,
    output logic               is_data,
    output logic               last
);
    import tfs_pkg::*;

    logic     busy_reg, busy_next;
    logic     mul_pend_reg, mul_pend_next;
    hdr_pos_t hdr_pos_reg, hdr_pos_next;
    coord_t   col_start_reg, col_start_next;
    coord_t   col_end_reg, col_end_next;
    coord_t   row_start_reg, row_start_next;
    coord_t   row_end_reg, row_end_next;
    coord_t   width_reg, width_next;
    coord_t   height_reg, height_next;
    color_t   color_reg, color_next;
    count_t   bytes_left_reg, bytes_left_next;
    logic     out_valid_reg, out_valid_next;
    byte_t    spi_byte_reg, spi_byte_next;
    logic     is_data_reg, is_data_next;
    logic     last_reg, last_next;

    logic              start;
    logic              produce;
    logic              hdr_active;
    byte_t             hdr_byte;
    logic              hdr_is_data;
    logic [AREA_W-1:0] area;

    assign advance    = !out_valid_reg || !out_stall;
    assign start      = ctl.valid && !ctl.pull && advance;
    assign produce    = ctl.valid && ctl.pull && advance && busy_reg;
    assign hdr_active = (hdr_pos_reg < HDR_DONE);
    assign area       = AREA_W'(width_reg) * AREA_W'(height_reg);

    always_comb
    begin
        hdr_is_data = 1'b1;
        unique case (hdr_pos_reg)
            HDR_COL_CMD:
            begin
                hdr_byte    = CMD_COLUMN_SET;
                hdr_is_data = 1'b0;
            end
            HDR_COL_X0_HI:  hdr_byte = byte_t'(col_start_reg >> BYTE_W);
            HDR_COL_X0_LO:  hdr_byte = col_start_reg[BYTE_W-1:0];
            HDR_COL_X1_HI:  hdr_byte = byte_t'(col_end_reg >> BYTE_W);
            HDR_COL_X1_LO:  hdr_byte = col_end_reg[BYTE_W-1:0];
            HDR_PAGE_CMD:
            begin
                hdr_byte    = CMD_PAGE_SET;
                hdr_is_data = 1'b0;
            end
            HDR_PAGE_Y0_HI: hdr_byte = byte_t'(row_start_reg >> BYTE_W);
            HDR_PAGE_Y0_LO: hdr_byte = row_start_reg[BYTE_W-1:0];
            HDR_PAGE_Y1_HI: hdr_byte = byte_t'(row_end_reg >> BYTE_W);
            HDR_PAGE_Y1_LO: hdr_byte = row_end_reg[BYTE_W-1:0];
            default:
            begin
                hdr_byte    = CMD_MEM_WRITE;
                hdr_is_data = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        busy_next       = busy_reg;
        mul_pend_next   = mul_pend_reg;
        hdr_pos_next    = hdr_pos_reg;
        col_start_next  = col_start_reg;
        col_end_next    = col_end_reg;
        row_start_next  = row_start_reg;
        row_end_next    = row_end_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        color_next      = color_reg;
        bytes_left_next = bytes_left_reg;
        out_valid_next  = out_valid_reg;
        spi_byte_next   = spi_byte_reg;
        is_data_next    = is_data_reg;
        last_next       = last_reg;

        // The pixel byte count is formed in the cycle after a start, well before the
        // header has been sent.
        if (mul_pend_reg)
        begin
            bytes_left_next = {area, 1'b0};
            mul_pend_next   = 1'b0;
        end

        if (start && !busy_reg && window.accept)
        begin
            col_start_next = window.col_start;
            col_end_next   = window.col_end;
            row_start_next = window.row_start;
            row_end_next   = window.row_end;
            width_next     = window.width;
            height_next    = window.height;
            color_next     = color;
            hdr_pos_next   = HDR_COL_CMD;
            busy_next      = 1'b1;
            mul_pend_next  = 1'b1;
        end

        if (advance)
        begin
            out_valid_next = produce;
        end

        if (produce)
        begin
            last_next = 1'b0;
            if (hdr_active)
            begin
                spi_byte_next = hdr_byte;
                is_data_next  = hdr_is_data;
                hdr_pos_next  = hdr_pos_reg + hdr_pos_t'(1);
                if ((hdr_pos_reg == HDR_MEM_CMD) && (bytes_left_reg == '0))
                begin
                    last_next = 1'b1;
                    busy_next = 1'b0;
                end
            end
            else
            begin
                is_data_next  = 1'b1;
                spi_byte_next = bytes_left_reg[0] ? color_reg[BYTE_W-1:0]
                                                  : color_reg[COLOR_W-1:BYTE_W];
                if (bytes_left_reg != '0)
                begin
                    bytes_left_next = bytes_left_reg - count_t'(1);
                end
                if (bytes_left_reg <= count_t'(1))
                begin
                    last_next = 1'b1;
                    busy_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            mul_pend_reg   <= 1'b0;
            hdr_pos_reg    <= HDR_COL_CMD;
            bytes_left_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            mul_pend_reg   <= mul_pend_next;
            hdr_pos_reg    <= hdr_pos_next;
            bytes_left_reg <= bytes_left_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_start_reg <= col_start_next;
        col_end_reg   <= col_end_next;
        row_start_reg <= row_start_next;
        row_end_reg   <= row_end_next;
        width_reg     <= width_next;
        height_reg    <= height_next;
        color_reg     <= color_next;
        spi_byte_reg  <= spi_byte_next;
        is_data_reg   <= is_data_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign spi_byte  = spi_byte_reg;
    assign is_data   = is_data_reg;
    assign last      = last_reg;

    // The byte count is still being formed only in the cycle straight after a start.
    a_pend_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        mul_pend_reg |-> (busy_reg && (hdr_pos_reg == HDR_COL_CMD)))
        else $error("byte count pending outside the first header cycle");

    a_header_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_pos_reg <= HDR_DONE)
        else $error("header position beyond the end of the header");

    a_pixels_remain: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !hdr_active) |-> (bytes_left_reg != '0))
        else $error("pixel phase busy with no bytes left");

    a_last_ends_stream: assert property (@(posedge clk) disable iff (!rst_n)
        (produce && last_next) |=> (!busy_reg && out_valid_reg && last_reg))
        else $error("final byte did not end the stream");

endmodule

@@ hw/rtl/tft_rect_fill_byte_streamer.sv @@
// Top level of the TFT rectangle fill byte streamer.
// Holds the configuration registers and the input register; uses tfs_clip and tfs_stream.
// Depends on tfs_pkg.
//
// The block takes one item in every clock cycle when its result side keeps up. An accepted
// item sits in an input register while the rectangle is clipped or the next byte of the
// stream is chosen, and the byte then waits in a result register, so a pull's byte
// reaches the output through the input register and then the result register. Both
// stages stall together while a result is held by out_stall. The pixel byte count, twice
// the clipped width times height, comes from one multiplier in the cycle after a start,
// which lies inside the eleven header bytes. The panel size registers are read only when
// a start item is evaluated.
module tft_rect_fill_byte_streamer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  tfs_pkg::coord_t        cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   op,
    input  tfs_pkg::coord_t        rect_x,
    input  tfs_pkg::coord_t        rect_y,
    input  tfs_pkg::coord_t        rect_w,
    input  tfs_pkg::coord_t        rect_h,
    input  tfs_pkg::color_t        fill_color,
    output logic                   out_valid,
    input  logic                   out_stall,
    output tfs_pkg::byte_t         spi_byte,
    output logic                   is_data,
    output logic                   last
);
    import tfs_pkg::*;

    coord_t    screen_width_reg;
    coord_t    screen_height_reg;
    logic      s1_valid_reg;
    logic      s1_op_reg;
    coord_t    s1_x_reg;
    coord_t    s1_y_reg;
    coord_t    s1_w_reg;
    coord_t    s1_h_reg;
    color_t    s1_color_reg;
    logic      advance;
    logic      in_accept;
    window_t   window;
    item_ctl_t ctl;

    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= SCREEN_WIDTH_RESET;
            screen_height_reg <= SCREEN_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                default:           screen_width_reg  <= screen_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg    <= op;
            s1_x_reg     <= rect_x;
            s1_y_reg     <= rect_y;
            s1_w_reg     <= rect_w;
            s1_h_reg     <= rect_h;
            s1_color_reg <= fill_color;
        end
    end

    assign ctl.valid = s1_valid_reg;
    assign ctl.pull  = s1_op_reg;

    tfs_clip u_clip (
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .rect_x        (s1_x_reg),
        .rect_y        (s1_y_reg),
        .rect_w        (s1_w_reg),
        .rect_h        (s1_h_reg),
        .window        (window)
    );

    tfs_stream u_stream (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .window    (window),
        .color     (s1_color_reg),
        .out_stall (out_stall),
        .advance   (advance),
        .out_valid (out_valid),
        .spi_byte  (spi_byte),
        .is_data   (is_data),
        .last      (last)
    );

endmodule
